// ----- hw/rtl/msic_pkg.sv -----
// Shared types and constants for the merge sort inversion counter.
// No dependencies; imported by every module of the block.
package msic_pkg;

    localparam int MAX_ITEMS = 64;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int SPAN_W    = CNT_W + 1;
    localparam int INV_W     = 11;

    typedef logic [DATA_W-1:0] t_data;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [SPAN_W-1:0] t_span;
    typedef logic [INV_W-1:0]  t_inv;

    typedef struct packed {
        t_data head_p;
        t_data head_q;
        t_cnt  p;
        t_cnt  q;
        t_cnt  mid;
        t_cnt  hi;
    } t_cmp_req;

    typedef struct packed {
        logic take_p;
        t_cnt inv_inc;
    } t_cmp_rsp;

endpackage

// ----- hw/rtl/msic_ram.sv -----
// Element bank: one write port and two registered write-first read ports.
// Depends on msic_pkg for widths.
module msic_ram import msic_pkg::*; (
    input  logic  i_clk,
    input  logic  i_we,
    input  t_addr i_waddr,
    input  t_data i_wdata,
    input  t_addr i_raddr_a,
    input  t_addr i_raddr_b,
    output t_data o_rdata_a,
    output t_data o_rdata_b
);

    t_data r_mem [MAX_ITEMS];
    t_data r_rdata_a;
    t_data r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // pass same-address write data through to the read port
        r_rdata_a <= (i_we && (i_waddr == i_raddr_a)) ? i_wdata : r_mem[i_raddr_a];
        r_rdata_b <= (i_we && (i_waddr == i_raddr_b)) ? i_wdata : r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- hw/rtl/msic_cmp.sv -----
// Shared merge step unit: picks the next head and counts the inversions it implies.
// Depends on msic_pkg for the request and response structs.
module msic_cmp import msic_pkg::*; (
    input  t_cmp_req i_req,
    output t_cmp_rsp o_rsp
);

    logic p_live;
    logic q_live;
    logic p_greater;

    assign p_live    = i_req.p < i_req.mid;
    assign q_live    = i_req.q < i_req.hi;
    assign p_greater = $signed(i_req.head_p) > $signed(i_req.head_q);

    assign o_rsp.take_p  = !q_live || (p_live && !p_greater);
    assign o_rsp.inv_inc = o_rsp.take_p ? '0 : (i_req.mid - i_req.p);

endmodule

// ----- hw/rtl/merge_sort_inversion_count.sv -----
// Merge sort with inversion count. Load: a new transaction may come in every idle cycle,
// busy stays low. Sort: bottom-up merge between two ping-pong banks, one element per cycle
// through the shared compare unit, with a setup state (S_SEG) before each merge segment.
// Output: one result per cycle, n results, each registered from the S_OUT state; the
// receiver cannot stall. Synchronous active-low reset clears count, inversion total, drop
// flag, strobe and sequencer; bank contents are undefined until written.
module merge_sort_inversion_count import msic_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    output logic  busy,
    input  t_data i_value,
    input  logic  i_is_last,
    output logic  o_strobe,
    output t_data o_sorted_value,
    output t_inv  o_inversions,
    output logic  o_overflow,
    output logic  o_is_final
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEG,
        S_MERGE,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_drop, n_drop;
    t_inv   r_inv, n_inv;
    t_cnt   r_width, n_width;
    t_cnt   r_lo, n_lo;
    t_cnt   r_mid, n_mid;
    t_cnt   r_hi, n_hi;
    t_cnt   r_p, n_p;
    t_cnt   r_q, n_q;
    t_cnt   r_k, n_k;
    logic   r_src, n_src;
    logic   r_strobe, n_strobe;
    t_data  r_sorted, n_sorted;
    t_inv   r_inv_out, n_inv_out;
    logic   r_ovf_out, n_ovf_out;
    logic   r_final, n_final;

    logic     we0, we1;
    t_addr    waddr;
    t_data    wdata;
    t_data    b0_a, b0_b, b1_a, b1_b;
    t_data    rd_a, rd_b;
    t_cmp_req cmp_req;
    t_cmp_rsp cmp_rsp;

    t_span n_span;
    t_span width2;
    t_span lo_mid;
    t_span lo_hi;

    msic_ram u_bank0 (
        .i_clk     (i_clk),
        .i_we      (we0),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (n_p[ADDR_W-1:0]),
        .i_raddr_b (n_q[ADDR_W-1:0]),
        .o_rdata_a (b0_a),
        .o_rdata_b (b0_b)
    );

    msic_ram u_bank1 (
        .i_clk     (i_clk),
        .i_we      (we1),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (n_p[ADDR_W-1:0]),
        .i_raddr_b (n_q[ADDR_W-1:0]),
        .o_rdata_a (b1_a),
        .o_rdata_b (b1_b)
    );

    assign rd_a = r_src ? b1_a : b0_a;
    assign rd_b = r_src ? b1_b : b0_b;

    assign cmp_req = '{head_p: rd_a, head_q: rd_b, p: r_p, q: r_q, mid: r_mid, hi: r_hi};

    msic_cmp u_cmp (
        .i_req (cmp_req),
        .o_rsp (cmp_rsp)
    );

    assign n_span = {1'b0, r_count};
    assign width2 = {1'b0, r_width} << 1;
    assign lo_mid = {1'b0, r_lo} + {1'b0, r_width};
    assign lo_hi  = {1'b0, r_lo} + width2;

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_drop    = r_drop;
        n_inv     = r_inv;
        n_width   = r_width;
        n_lo      = r_lo;
        n_mid     = r_mid;
        n_hi      = r_hi;
        n_p       = r_p;
        n_q       = r_q;
        n_k       = r_k;
        n_src     = r_src;
        n_strobe  = 1'b0;
        n_sorted  = r_sorted;
        n_inv_out = r_inv_out;
        n_ovf_out = r_ovf_out;
        n_final   = r_final;
        we0       = 1'b0;
        we1       = 1'b0;
        waddr     = r_k[ADDR_W-1:0];
        wdata     = cmp_rsp.take_p ? rd_a : rd_b;

        unique case (r_state)
            S_IDLE: begin
                waddr = r_count[ADDR_W-1:0];
                wdata = i_value;
                if (start) begin
                    if (r_count < CNT_W'(MAX_ITEMS)) begin
                        we0     = 1'b1;
                        n_count = r_count + 1'b1;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_is_last) begin
                        n_src   = 1'b0;
                        n_width = CNT_W'(1);
                        n_lo    = '0;
                        n_p     = '0;
                        n_state = (n_count > CNT_W'(1)) ? S_SEG : S_OUT;
                    end
                end
            end
            S_SEG: begin
                n_mid   = (lo_mid > n_span) ? r_count : lo_mid[CNT_W-1:0];
                n_hi    = (lo_hi > n_span) ? r_count : lo_hi[CNT_W-1:0];
                n_p     = r_lo;
                n_q     = n_mid;
                n_k     = r_lo;
                n_state = S_MERGE;
            end
            S_MERGE: begin
                we0   = r_src;
                we1   = !r_src;
                n_k   = r_k + 1'b1;
                n_inv = r_inv + INV_W'(cmp_rsp.inv_inc);
                if (cmp_rsp.take_p) begin
                    n_p = r_p + 1'b1;
                end else begin
                    n_q = r_q + 1'b1;
                end
                if (n_k == r_hi) begin
                    if (lo_hi >= n_span) begin
                        n_src   = !r_src;
                        n_width = width2[CNT_W-1:0];
                        n_lo    = '0;
                        if (width2 >= n_span) begin
                            n_p     = '0;
                            n_state = S_OUT;
                        end else begin
                            n_state = S_SEG;
                        end
                    end else begin
                        n_lo    = lo_hi[CNT_W-1:0];
                        n_state = S_SEG;
                    end
                end
            end
            S_OUT: begin
                n_strobe  = 1'b1;
                n_sorted  = rd_a;
                n_inv_out = r_inv;
                n_ovf_out = r_drop;
                n_final   = (r_p + 1'b1) == r_count;
                n_p       = r_p + 1'b1;
                if (n_final) begin
                    n_count = '0;
                    n_inv   = '0;
                    n_drop  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_inv    <= '0;
            r_src    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_inv     <= n_inv;
            r_width   <= n_width;
            r_lo      <= n_lo;
            r_mid     <= n_mid;
            r_hi      <= n_hi;
            r_p       <= n_p;
            r_q       <= n_q;
            r_k       <= n_k;
            r_src     <= n_src;
            r_strobe  <= n_strobe;
            r_sorted  <= n_sorted;
            r_inv_out <= n_inv_out;
            r_ovf_out <= n_ovf_out;
            r_final   <= n_final;
        end
    end

    assign busy           = r_state != S_IDLE;
    assign o_strobe       = r_strobe;
    assign o_sorted_value = r_sorted;
    assign o_inversions   = r_inv_out;
    assign o_overflow     = r_ovf_out;
    assign o_is_final     = r_final;

endmodule

// ----- hw/rtl/msic_chk.sv -----
// Port-level checks for the merge sort inversion counter, bound to the top level.
// Depends on msic_pkg for widths.
module msic_chk import msic_pkg::*; (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  start,
    input logic  busy,
    input t_data i_value,
    input logic  i_is_last,
    input logic  o_strobe,
    input t_data o_sorted_value,
    input t_inv  o_inversions,
    input logic  o_overflow,
    input logic  o_is_final
);

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_is_last) |=> busy)
        else $error("closing transaction did not start the sort");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_is_last) |=> !busy)
        else $error("load transaction left the block busy");

    a_result_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (busy || o_is_final))
        else $error("result outside a run");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_is_final) |=>
            (o_strobe && $stable(o_inversions) && $stable(o_overflow)))
        else $error("results of a run not contiguous or totals changed");

    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_is_final) |=> !o_strobe)
        else $error("result after the final one");

endmodule

bind merge_sort_inversion_count msic_chk u_msic_chk (.*);
